[hdl/btr_pkg.sv]
`timescale 1ns / 1ps

package btr_pkg;

	localparam int TAG_DEPTH_DEF = 32;
	localparam int MAX_WORDS     = 64;
	localparam int CNT_W         = 7;
	localparam int STR_CHARS     = 31;
	localparam int STR_LEN_W     = 5;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	// words kept free after a payload echo for the closing string
	localparam logic [CNT_W-1:0] ECHO_LIMIT_WG = CNT_W'(MAX_WORDS - 15);
	localparam logic [CNT_W-1:0] ECHO_LIMIT_FN = CNT_W'(MAX_WORDS - 2);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_B, ST_DECODE, ST_STR_A, ST_PAY_RD, ST_PAY_CHK,
		ST_VAL_CHK, ST_VAL_OUT, ST_STR_B, ST_FLUSH
	} state_t;

	typedef enum logic [1:0] {PM_NONE, PM_ECHO, PM_VALUE} pmode_t;

	typedef enum logic [4:0] {
		S_NONE, S_SMALL_OPEN, S_SMALL_CLOSE, S_I_OPEN, S_I_CLOSE, S_I_CLOSE_SP,
		S_FN_OPEN, S_FN_CLOSE, S_B_OPEN, S_B_CLOSE, S_RED_OPEN, S_FONT_CLOSE,
		S_U_OPEN, S_U_CLOSE, S_CITE_OPEN, S_CITE_CLOSE, S_SUP_OPEN, S_SUP_CLOSE,
		S_SUB_OPEN, S_SUB_CLOSE, S_FACE_OPEN, S_FACE_CLOSE, S_BR_SP, S_BR,
		S_DIV_RIGHT, S_DIV_CENTER, S_CENTER_CLOSE, S_DIV_CLOSE, S_BIG_OPEN,
		S_BIG_CLOSE
	} str_id_t;

	typedef struct packed {
		logic [STR_LEN_W-1:0]   len;
		logic [STR_CHARS*8-1:0] bits;   // right-aligned, last char in low byte
	} str_t;

	typedef struct packed {
		logic       push;     // append byte behind the held one
		logic       flush;    // send held byte as the last of the run
		logic       direct;   // single-byte run straight to output
		logic [7:0] data;
	} emit_cmd_t;

	typedef struct packed {
		logic load_ok;
		logic push_ok;
		logic hold_v;
	} emit_sts_t;

	function automatic str_t str_rom(input str_id_t id);
		str_t r;
		r.bits = '0;
		r.len  = '0;
		unique case (id)
			S_SMALL_OPEN:   begin r.bits = " <small><em>"; r.len = 5'd12; end
			S_SMALL_CLOSE:  begin r.bits = "</em></small> "; r.len = 5'd14; end
			S_I_OPEN:       begin r.bits = "<i>"; r.len = 5'd3; end
			S_I_CLOSE:      begin r.bits = "</i>"; r.len = 5'd4; end
			S_I_CLOSE_SP:   begin r.bits = "</i> "; r.len = 5'd5; end
			S_FN_OPEN:      begin r.bits = "<font color=\"#800000\"> <small>("; r.len = 5'd31; end
			S_FN_CLOSE:     begin r.bits = ")</small> </font>"; r.len = 5'd17; end
			S_B_OPEN:       begin r.bits = "<b>"; r.len = 5'd3; end
			S_B_CLOSE:      begin r.bits = "</b>"; r.len = 5'd4; end
			S_RED_OPEN:     begin r.bits = "<font color=#FF0000>"; r.len = 5'd20; end
			S_FONT_CLOSE:   begin r.bits = "</font>"; r.len = 5'd7; end
			S_U_OPEN:       begin r.bits = "<u>"; r.len = 5'd3; end
			S_U_CLOSE:      begin r.bits = "</u>"; r.len = 5'd4; end
			S_CITE_OPEN:    begin r.bits = "<cite>"; r.len = 5'd6; end
			S_CITE_CLOSE:   begin r.bits = "</cite>"; r.len = 5'd7; end
			S_SUP_OPEN:     begin r.bits = "<sup>"; r.len = 5'd5; end
			S_SUP_CLOSE:    begin r.bits = "</sup>"; r.len = 5'd6; end
			S_SUB_OPEN:     begin r.bits = "<sub>"; r.len = 5'd5; end
			S_SUB_CLOSE:    begin r.bits = "</sub>"; r.len = 5'd6; end
			S_FACE_OPEN:    begin r.bits = "<font face=\""; r.len = 5'd12; end
			S_FACE_CLOSE:   begin r.bits = "\">"; r.len = 5'd2; end
			S_BR_SP:        begin r.bits = "<br /> "; r.len = 5'd7; end
			S_BR:           begin r.bits = "<br />"; r.len = 5'd6; end
			S_DIV_RIGHT:    begin r.bits = "<div align=\"right\">"; r.len = 5'd19; end
			S_DIV_CENTER:   begin r.bits = "<div align=\"center\">"; r.len = 5'd20; end
			S_CENTER_CLOSE: begin r.bits = "</center>"; r.len = 5'd9; end
			S_DIV_CLOSE:    begin r.bits = "</div>"; r.len = 5'd6; end
			S_BIG_OPEN:     begin r.bits = "<big>"; r.len = 5'd5; end
			S_BIG_CLOSE:    begin r.bits = "</big>"; r.len = 5'd6; end
			default:        begin r.bits = '0; r.len = '0; end
		endcase
		return r;
	endfunction

endpackage

[hdl/btr_tag_ram.sv]
`timescale 1ns / 1ps

module btr_tag_ram #(
	parameter int TAG_DEPTH = btr_pkg::TAG_DEPTH_DEF,
	localparam int AW = $clog2(TAG_DEPTH)
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [TAG_DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

[hdl/btr_out_stage.sv]
`timescale 1ns / 1ps

// One-byte hold plus output register; the hold lets run_last be set on the
// final byte without lookahead.
module btr_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  btr_pkg::emit_cmd_t   cmd,
	output btr_pkg::emit_sts_t   sts,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // [7:0] out_char
	output logic                 m_tlast    // run_last
);

	logic       out_v_q;
	logic [7:0] out_data_q;
	logic       out_last_q;
	logic       hold_v_q;
	logic [7:0] hold_q;
	logic       load;

	assign sts.load_ok = !out_v_q || m_tready;
	assign sts.push_ok = !hold_v_q || sts.load_ok;
	assign sts.hold_v  = hold_v_q;
	assign load = cmd.direct || cmd.flush || (cmd.push && hold_v_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			hold_v_q <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			if (cmd.push) begin
				hold_v_q <= 1'b1;
			end else if (cmd.flush) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.direct) begin
			out_data_q <= cmd.data;
			out_last_q <= 1'b1;
		end else if (cmd.flush) begin
			out_data_q <= hold_q;
			out_last_q <= 1'b1;
		end else if (cmd.push && hold_v_q) begin
			out_data_q <= hold_q;
			out_last_q <= 1'b0;
		end
		if (cmd.push) begin
			hold_q <= cmd.data;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

[hdl/btr_ctrl.sv]
`timescale 1ns / 1ps

module btr_ctrl #(
	parameter int TAG_DEPTH = btr_pkg::TAG_DEPTH_DEF,
	localparam int AW = $clog2(TAG_DEPTH),
	localparam int LW = $clog2(TAG_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,
	output logic                 mem_en,
	output logic                 mem_we,
	output logic [AW-1:0]        mem_addr,
	output logic [7:0]           mem_wdata,
	input  logic [7:0]           mem_rdata,
	output btr_pkg::emit_cmd_t   cmd,
	input  btr_pkg::emit_sts_t   sts
);

	btr_pkg::state_t  state_q, state_d;
	btr_pkg::str_id_t stra_q, strb_q, stra_d, strb_d, cur_id;
	btr_pkg::pmode_t  pmode_q, pmode_d;
	btr_pkg::str_t    cur_str;

	logic [LW-1:0]              len_q, i_q;
	logic [btr_pkg::STR_LEN_W-1:0] k_q, sel;
	logic [btr_pkg::CNT_W-1:0]  cnt_q, limit_q, limit_d;
	logic                       inside_q, fp_q, ra_q, ce_q;
	logic                       fp_d, ra_d, ce_d;
	logic                       neg_q, dig_q;
	logic [7:0]                 acc_q, a_q, ca, cb, c;
	logic                       accept, str_done, rd_ok, consume;
	logic                       is_ws, is_dig, is_sign;

	assign c      = (s_tdata == btr_pkg::CH_LF) ? btr_pkg::CH_SP : s_tdata;
	assign accept = s_tvalid && s_tready;
	assign cur_id = (state_q == btr_pkg::ST_STR_A) ? stra_q : strb_q;
	assign cur_str = btr_pkg::str_rom(cur_id);
	assign str_done = (k_q == cur_str.len);
	assign sel = cur_str.len - k_q - btr_pkg::STR_LEN_W'(1);
	assign rd_ok = (i_q < len_q) && ((pmode_q == btr_pkg::PM_VALUE) || (cnt_q < limit_q));

	assign ca = (len_q >= LW'(1)) ? a_q : 8'h00;
	assign cb = (len_q >= LW'(2)) ? mem_rdata : 8'h00;

	// number parsing on the byte just read
	assign is_ws   = (mem_rdata == btr_pkg::CH_SP) ||
	                 (mem_rdata >= btr_pkg::CH_TAB && mem_rdata <= btr_pkg::CH_CR);
	assign is_dig  = (mem_rdata >= btr_pkg::CH_0 && mem_rdata <= btr_pkg::CH_9);
	assign is_sign = (mem_rdata == btr_pkg::CH_PLUS) || (mem_rdata == btr_pkg::CH_MINUS);
	assign consume = dig_q ? is_dig : (is_ws || is_sign || is_dig);

	// tag decode: first letter in a_q, second on the RAM read port
	always_comb begin
		stra_d  = btr_pkg::S_NONE;
		strb_d  = btr_pkg::S_NONE;
		pmode_d = btr_pkg::PM_NONE;
		limit_d = '0;
		fp_d = fp_q;
		ra_d = ra_q;
		ce_d = ce_q;
		unique case (ca)
			"W": if (cb == "G" || cb == "H" || cb == "T") begin
				stra_d = btr_pkg::S_SMALL_OPEN; pmode_d = btr_pkg::PM_ECHO;
				limit_d = btr_pkg::ECHO_LIMIT_WG; strb_d = btr_pkg::S_SMALL_CLOSE;
			end
			"R": if (cb == "B") begin
				stra_d = btr_pkg::S_I_OPEN; fp_d = 1'b1;
			end else if (cb == "F") begin
				if (fp_q) stra_d = btr_pkg::S_I_CLOSE_SP;
				strb_d = btr_pkg::S_FN_OPEN;
			end else if (cb == "f") begin
				stra_d = btr_pkg::S_FN_CLOSE; fp_d = 1'b0;
			end
			"F": unique case (cb)
				"I": stra_d = btr_pkg::S_I_OPEN;
				"i": stra_d = btr_pkg::S_I_CLOSE;
				"B": stra_d = btr_pkg::S_B_OPEN;
				"b": stra_d = btr_pkg::S_B_CLOSE;
				"R": stra_d = btr_pkg::S_RED_OPEN;
				"r": stra_d = btr_pkg::S_FONT_CLOSE;
				"U": stra_d = btr_pkg::S_U_OPEN;
				"u": stra_d = btr_pkg::S_U_CLOSE;
				"O": stra_d = btr_pkg::S_CITE_OPEN;
				"o": stra_d = btr_pkg::S_CITE_CLOSE;
				"S": stra_d = btr_pkg::S_SUP_OPEN;
				"s": stra_d = btr_pkg::S_SUP_CLOSE;
				"V": stra_d = btr_pkg::S_SUB_OPEN;
				"v": stra_d = btr_pkg::S_SUB_CLOSE;
				"N": begin
					stra_d = btr_pkg::S_FACE_OPEN; pmode_d = btr_pkg::PM_ECHO;
					limit_d = btr_pkg::ECHO_LIMIT_FN; strb_d = btr_pkg::S_FACE_CLOSE;
				end
				"n": stra_d = btr_pkg::S_FONT_CLOSE;
				default: ;
			endcase
			"C": if (cb == "A") begin
				pmode_d = btr_pkg::PM_VALUE;
			end else if (cb == "L") begin
				stra_d = btr_pkg::S_BR_SP;
			end else if (cb == "M") begin
				stra_d = btr_pkg::S_BR;
			end
			"J": if (cb == "R") begin
				stra_d = btr_pkg::S_DIV_RIGHT; ra_d = 1'b1;
			end else if (cb == "C") begin
				stra_d = btr_pkg::S_DIV_CENTER; ce_d = 1'b1;
			end else if (cb == "L") begin
				if (ce_q) stra_d = btr_pkg::S_CENTER_CLOSE;
				if (ra_q) strb_d = btr_pkg::S_DIV_CLOSE;
				ce_d = 1'b0;
				ra_d = 1'b0;
			end
			"T": if (cb == "T") stra_d = btr_pkg::S_BIG_OPEN;
				else if (cb == "t") stra_d = btr_pkg::S_BIG_CLOSE;
			"P": if (cb == "P") stra_d = btr_pkg::S_CITE_OPEN;
				else if (cb == "p") stra_d = btr_pkg::S_CITE_CLOSE;
			default: ;
		endcase
	end

	// next state, RAM port and emit commands
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = c;
		cmd       = '0;
		unique case (state_q)
			btr_pkg::ST_IDLE: begin
				s_tready = sts.load_ok;
				cmd.data = c;
				if (accept) begin
					if (c == btr_pkg::CH_GT) begin
						mem_en  = 1'b1;
						state_d = btr_pkg::ST_RD_B;
					end else if (c != btr_pkg::CH_LT) begin
						if (inside_q) begin
							mem_en   = (len_q < LW'(TAG_DEPTH));
							mem_we   = 1'b1;
							mem_addr = len_q[AW-1:0];
						end else begin
							cmd.direct = 1'b1;
						end
					end
				end
			end
			btr_pkg::ST_RD_B: begin
				mem_en   = 1'b1;
				mem_addr = AW'(1);
				state_d  = btr_pkg::ST_DECODE;
			end
			btr_pkg::ST_DECODE: state_d = btr_pkg::ST_STR_A;
			btr_pkg::ST_STR_A, btr_pkg::ST_STR_B: begin
				cmd.data = cur_str.bits[{sel, 3'b000} +: 8];
				if (str_done) begin
					if (state_q == btr_pkg::ST_STR_B) state_d = btr_pkg::ST_FLUSH;
					else if (pmode_q == btr_pkg::PM_NONE) state_d = btr_pkg::ST_STR_B;
					else state_d = btr_pkg::ST_PAY_RD;
				end else begin
					cmd.push = sts.push_ok;
				end
			end
			btr_pkg::ST_PAY_RD: begin
				mem_addr = i_q[AW-1:0];
				if (rd_ok) begin
					mem_en  = 1'b1;
					state_d = (pmode_q == btr_pkg::PM_ECHO) ? btr_pkg::ST_PAY_CHK
					                                        : btr_pkg::ST_VAL_CHK;
				end else begin
					state_d = (pmode_q == btr_pkg::PM_VALUE) ? btr_pkg::ST_VAL_OUT
					                                         : btr_pkg::ST_STR_B;
				end
			end
			btr_pkg::ST_PAY_CHK: begin
				cmd.data = mem_rdata;
				if (mem_rdata == 8'h00) begin
					state_d = btr_pkg::ST_STR_B;
				end else if (sts.push_ok) begin
					cmd.push = 1'b1;
					state_d  = btr_pkg::ST_PAY_RD;
				end
			end
			btr_pkg::ST_VAL_CHK:
				state_d = consume ? btr_pkg::ST_PAY_RD : btr_pkg::ST_VAL_OUT;
			btr_pkg::ST_VAL_OUT: begin
				cmd.data = neg_q ? (8'h00 - acc_q) : acc_q;
				if (sts.push_ok) begin
					cmd.push = 1'b1;
					state_d  = btr_pkg::ST_STR_B;
				end
			end
			btr_pkg::ST_FLUSH: begin
				if (!sts.hold_v) begin
					state_d = btr_pkg::ST_IDLE;
				end else if (sts.load_ok) begin
					cmd.flush = 1'b1;
					state_d   = btr_pkg::ST_IDLE;
				end
			end
			default: state_d = btr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			len_q    <= '0;
			fp_q     <= 1'b0;
			ra_q     <= 1'b0;
			ce_q     <= 1'b0;
		end else begin
			if (accept) begin
				if (c == btr_pkg::CH_LT) begin
					inside_q <= 1'b1;
					len_q    <= '0;
				end else if (c == btr_pkg::CH_GT) begin
					inside_q <= 1'b0;
				end else if (inside_q && len_q < LW'(TAG_DEPTH)) begin
					len_q <= len_q + LW'(1);
				end
			end
			if (state_q == btr_pkg::ST_DECODE) begin
				fp_q <= fp_d;
				ra_q <= ra_d;
				ce_q <= ce_d;
			end
		end
	end

	// run datapath
	always_ff @(posedge clk) begin
		if (state_q == btr_pkg::ST_RD_B) begin
			a_q <= mem_rdata;
		end
		if (accept) begin
			cnt_q <= '0;
		end else if (cmd.push) begin
			cnt_q <= cnt_q + btr_pkg::CNT_W'(1);
		end
		if (state_q == btr_pkg::ST_DECODE) begin
			stra_q  <= stra_d;
			strb_q  <= strb_d;
			pmode_q <= pmode_d;
			limit_q <= limit_d;
			k_q     <= '0;
			i_q     <= LW'(2);
			acc_q   <= '0;
			neg_q   <= 1'b0;
			dig_q   <= 1'b0;
		end else if ((state_q == btr_pkg::ST_STR_A || state_q == btr_pkg::ST_STR_B)) begin
			if (str_done) k_q <= '0;
			else if (sts.push_ok) k_q <= k_q + btr_pkg::STR_LEN_W'(1);
		end else if (state_q == btr_pkg::ST_PAY_CHK && cmd.push) begin
			i_q <= i_q + LW'(1);
		end else if (state_q == btr_pkg::ST_VAL_CHK && consume) begin
			i_q <= i_q + LW'(1);
			if (!dig_q && is_sign) begin
				neg_q <= (mem_rdata == btr_pkg::CH_MINUS);
				dig_q <= 1'b1;
			end
			if (is_dig) begin
				acc_q <= {acc_q[4:0], 3'b000} + {acc_q[6:0], 1'b0} + (mem_rdata - btr_pkg::CH_0);
				dig_q <= 1'b1;
			end
		end
	end

endmodule

[hdl/bracket_tag_to_html_rewriter.sv]
`timescale 1ns / 1ps

// Rewrites a byte stream of bracket tags into HTML. Each input word is one text
// byte; each output word is one HTML byte, with tlast on the final byte caused
// by an input word (inputs that cause nothing give no output). A byte outside a
// tag goes straight to the output register; bytes after '<' are written to
// the tag RAM (TAG_DEPTH bytes, extra bytes dropped). A '>' reads the first two
// tag bytes from the RAM, then plays a first and a second fixed string from a
// ROM at one byte per cycle while the output stage has room; payload echo and
// the decimal value of the payload read the RAM back one byte at a time, each
// read followed by a check of that byte, set by the single RAM port and its
// registered read. Input is taken only between runs, so a new byte waits until
// the run of the last one is done and the output register has room.
module bracket_tag_to_html_rewriter #(
	parameter int TAG_DEPTH = btr_pkg::TAG_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] in_char
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // [7:0] out_char
	output logic       m_tlast     // run_last
);

	localparam int AW = $clog2(TAG_DEPTH);

	logic               mem_en, mem_we;
	logic [AW-1:0]      mem_addr;
	logic [7:0]         mem_wdata, mem_rdata;
	btr_pkg::emit_cmd_t cmd;
	btr_pkg::emit_sts_t sts;

	// tag buffer
	btr_tag_ram #(.TAG_DEPTH(TAG_DEPTH)) u_ram (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// tag tracking, decode and run sequencing
	btr_ctrl #(.TAG_DEPTH(TAG_DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.mem_en    (mem_en),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata),
		.cmd       (cmd),
		.sts       (sts)
	);

	// output register with last-byte hold
	btr_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

[hdl/btr_checker.sv]
`timescale 1ns / 1ps

module btr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// input is only taken when the output register is free
	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid || m_tready)
		else $error("input ready while output blocked");

	// a tag open produces no output word
	a_open_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata == btr_pkg::CH_LT |=> !m_tvalid)
		else $error("output after tag open");

endmodule

bind bracket_tag_to_html_rewriter btr_checker u_btr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

// Stream-level check of the bracket tag rewriter. Bytes go in on the slave
// side. A behavioral copy of the rewriter works out the HTML words that each
// accepted byte should cause. Every output word is compared with the oldest
// outstanding one.
module tb_top;

	localparam int TAG_DEPTH  = btr_pkg::TAG_DEPTH_DEF;
	localparam int WDOG_LIMIT = 4000;   // idle cycles with no word moving on either side
	localparam int N_RANDOM   = 175;
	localparam int N_QUIET    = 40;     // last bytes are sent with no idling

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} html_word_t;

	typedef struct {
		string txt;
		bit    known;   // exp is typed in; otherwise the shadow rewriter decides
		string exp;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;     // [7:0] in_char
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;     // [7:0] out_char
	logic       m_tlast;     // run_last

	bracket_tag_to_html_rewriter #(.TAG_DEPTH(TAG_DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	// shadow state of the rewriter
	logic [7:0] sh_tag [TAG_DEPTH];
	int         sh_len;
	bit         sh_in_tag, sh_footnote, sh_right, sh_center;
	logic [7:0] run_q [$];          // words caused by the byte being predicted
	html_word_t pending_html [$];   // words still owed by the block

	int  mismatches;
	int  idle_cycles;
	bit  quiet;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic put_ch(input logic [7:0] c);
		if (run_q.size() < btr_pkg::MAX_WORDS)
			run_q.push_back(c);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_ch(s[i]);
	endtask

	// tail = words kept free for the closing string
	task automatic put_payload(input int tail);
		for (int i = 2; i < sh_len && i < TAG_DEPTH; i++) begin
			if (sh_tag[i] == 8'h00 || run_q.size() >= btr_pkg::MAX_WORDS - tail)
				break;
			put_ch(sh_tag[i]);
		end
	endtask

	// decimal value of the payload, wrapping mod 256
	function automatic logic [7:0] payload_dec();
		int i;
		logic [7:0] acc;
		bit neg;
		i = 2;
		acc = '0;
		neg = 1'b0;
		while (i < sh_len && i < TAG_DEPTH &&
		       (sh_tag[i] == btr_pkg::CH_SP ||
		        (sh_tag[i] >= btr_pkg::CH_TAB && sh_tag[i] <= btr_pkg::CH_CR)))
			i++;
		if (i < sh_len && i < TAG_DEPTH &&
		    (sh_tag[i] == btr_pkg::CH_PLUS || sh_tag[i] == btr_pkg::CH_MINUS)) begin
			neg = (sh_tag[i] == btr_pkg::CH_MINUS);
			i++;
		end
		while (i < sh_len && i < TAG_DEPTH &&
		       sh_tag[i] >= btr_pkg::CH_0 && sh_tag[i] <= btr_pkg::CH_9) begin
			acc = acc * 8'd10 + (sh_tag[i] - btr_pkg::CH_0);
			i++;
		end
		return neg ? 8'd0 - acc : acc;
	endfunction

	task automatic decode_close();
		logic [7:0] a, b;
		a = (sh_len >= 1) ? sh_tag[0] : 8'h00;
		b = (sh_len >= 2) ? sh_tag[1] : 8'h00;
		case (a)
			"W": if (b == "G" || b == "H" || b == "T") begin
				put_text(" <small><em>");
				put_payload(15);
				put_text("</em></small> ");
			end
			"R": begin
				if (b == "B") begin
					put_text("<i>");
					sh_footnote = 1'b1;
				end else if (b == "F") begin
					if (sh_footnote)
						put_text("</i> ");
					put_text("<font color=\"#800000\"> <small>(");
				end else if (b == "f") begin
					put_text(")</small> </font>");
					sh_footnote = 1'b0;
				end
			end
			"F": case (b)
				"I": put_text("<i>");
				"i": put_text("</i>");
				"B": put_text("<b>");
				"b": put_text("</b>");
				"R": put_text("<font color=#FF0000>");
				"r": put_text("</font>");
				"U": put_text("<u>");
				"u": put_text("</u>");
				"O": put_text("<cite>");
				"o": put_text("</cite>");
				"S": put_text("<sup>");
				"s": put_text("</sup>");
				"V": put_text("<sub>");
				"v": put_text("</sub>");
				"N": begin
					put_text("<font face=\"");
					put_payload(2);
					put_text("\">");
				end
				"n": put_text("</font>");
				default: ;
			endcase
			"C": begin
				if (b == "A")
					put_ch(payload_dec());
				else if (b == "L")
					put_text("<br /> ");
				else if (b == "M")
					put_text("<br />");
			end
			"J": begin
				if (b == "R") begin
					put_text("<div align=\"right\">");
					sh_right = 1'b1;
				end else if (b == "C") begin
					put_text("<div align=\"center\">");
					sh_center = 1'b1;
				end else if (b == "L") begin
					if (sh_center) begin
						put_text("</center>");
						sh_center = 1'b0;
					end
					if (sh_right) begin
						put_text("</div>");
						sh_right = 1'b0;
					end
				end
			end
			"T": if (b == "T") put_text("<big>"); else if (b == "t") put_text("</big>");
			"P": if (b == "P") put_text("<cite>"); else if (b == "p") put_text("</cite>");
			default: ;
		endcase
	endtask

	// advance the shadow state by one byte; the words it causes land in run_q
	task automatic rewrite_byte(input logic [7:0] c);
		run_q.delete();
		if (c == btr_pkg::CH_LF)
			c = btr_pkg::CH_SP;
		if (c == btr_pkg::CH_LT) begin
			sh_in_tag = 1'b1;
			sh_len = 0;
		end else if (c == btr_pkg::CH_GT) begin
			sh_in_tag = 1'b0;
			decode_close();
		end else if (sh_in_tag) begin
			if (sh_len < TAG_DEPTH) begin
				sh_tag[sh_len] = c;
				sh_len++;
			end
		end else begin
			put_ch(c);
		end
	endtask

	task automatic owe_words();
		html_word_t w;
		foreach (run_q[i]) begin
			w.ch = run_q[i];
			w.last = (i == run_q.size() - 1);
			pending_html.push_back(w);
		end
	endtask

	// present one byte, hold it until taken, then predict
	task automatic send_byte(input logic [7:0] c, input bit use_exp, input string exp);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata  <= 8'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		do @(posedge clk); while (!s_tready);
		rewrite_byte(c);
		if (use_exp) begin
			run_q.delete();
			put_text(exp);
		end
		owe_words();
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0, "");
	endtask

	// payload byte: anything but a tag bracket
	function automatic logic [7:0] pay_byte();
		logic [7:0] c;
		do c = 8'($urandom); while (c == btr_pkg::CH_LT || c == btr_pkg::CH_GT);
		return c;
	endfunction

	function automatic string num_payload();
		string s, pre;
		int n;
		s = "";
		pre = "  \t\r\n";
		repeat ($urandom_range(0, 2)) s = {s, string'(pre[$urandom_range(0, 4)])};
		case ($urandom_range(0, 2))
			0: s = {s, "-"};
			1: s = {s, "+"};
			default: ;
		endcase
		n = $urandom_range(0, 5);
		repeat (n) s = {s, string'(8'(btr_pkg::CH_0 + $urandom_range(0, 9)))};
		if ($urandom_range(0, 2) == 0)
			s = {s, "x7"};
		return s;
	endfunction

	// receiver: stalls at random
	int stall_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left <= 0;
			m_tready   <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 2);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// output checker and watchdog
	always @(posedge clk) begin
		html_word_t w;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", WDOG_LIMIT);
				$display("** bracket_tag_to_html_rewriter: FAILED **");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				if (pending_html.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected word %h last=%b", $realtime, m_tdata, m_tlast);
				end else begin
					w = pending_html.pop_front();
					if (m_tdata !== w.ch || m_tlast !== w.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: word exp %h last=%b, got %h last=%b",
								$realtime, w.ch, w.last, m_tdata, m_tlast);
					end
				end
			end
		end
	end

	stim_row_t rows [] = '{
		'{">",                  1'b1, ""},        // stray close right after reset
		'{"A",                  1'b1, "A"},
		'{"\n",                 1'b1, " "},
		'{"<FB>",               1'b1, "<b>"},
		'{"<Fb>",               1'b1, "</b>"},
		'{"<>",                 1'b1, ""},        // letters missing
		'{"<F>",                1'b1, ""},
		'{"<ZZ>",               1'b1, ""},        // unknown code
		'{"<CA255>",            1'b1, "\377"},
		'{"<CA256>",            1'b0, ""},        // wraps to a zero byte
		'{"<CA \t-1z>",         1'b0, ""},
		'{"<CA+>",              1'b0, ""},
		'{"<RF><RB><RF><Rf>",   1'b0, ""},
		'{"<JL><JR><JC><JL>",   1'b0, ""},
		'{"<WGsome text>",      1'b0, ""},
		'{"<WH><WTx\ny>",       1'b0, ""},
		'{"<FNSerif><Fn>",      1'b0, ""},
		'{"<FI><Fi><FR><Fr><FU><Fu><FO><Fo>", 1'b0, ""},
		'{"<FS><Fs><FV><Fv><TT><Tt><PP><Pp>", 1'b0, ""},
		'{"<CL><CM><CG><CT>",   1'b0, ""},
		'{"<F\nI>",             1'b0, ""},        // newline inside a tag
		'{"<WG<FB>",            1'b0, ""},        // nested open restarts
		'{">",                  1'b0, ""},        // stray close repeats last tag
		'{"<WGabcdefghijklmnopqrstuvwxyz0123456789ABCD>", 1'b0, ""} // buffer full
	};

	string codes [] = '{"WG", "WH", "WT", "RB", "RF", "Rf", "FI", "Fi", "FB", "Fb",
		"FR", "Fr", "FU", "Fu", "FO", "Fo", "FS", "Fs", "FV", "Fv", "FN", "Fn",
		"CA", "CG", "CT", "CL", "CM", "JR", "JC", "JL", "TT", "Tt", "PP", "Pp"};

	initial begin
		string code;
		int sent, n;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		mismatches = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		sh_len = 0;
		sh_in_tag = 1'b0;
		sh_footnote = 1'b0;
		sh_right = 1'b0;
		sh_center = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[r]) begin
			for (int i = 0; i < rows[r].txt.len(); i++)
				send_byte(rows[r].txt[i], rows[r].known && i == rows[r].txt.len() - 1,
					rows[r].exp);
		end
		send_byte(8'h00, 1'b0, "");   // zero byte passes through
		send_byte(8'hFF, 1'b1, "\377");

		// mostly well-formed tags with random content, some noise
		sent = 0;
		while (sent < N_RANDOM) begin
			if (sent >= N_RANDOM - N_QUIET)
				quiet = 1'b1;
			case ($urandom_range(0, 9))
				0, 1: begin
					n = $urandom_range(1, 4);
					repeat (n) send_byte(8'($urandom), 1'b0, "");
					sent += n;
				end
				2: begin
					send_byte($urandom_range(0, 1) ? btr_pkg::CH_LT : btr_pkg::CH_GT, 1'b0, "");
					sent++;
				end
				default: begin
					code = codes[$urandom_range(0, codes.size() - 1)];
					send_text({"<", code});
					sent += 3;
					if (code == "CA") begin
						code = num_payload();
						send_text(code);
						sent += code.len();
					end else if (code[0] == "W" || code == "FN" || $urandom_range(0, 5) == 0) begin
						n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40)
							: $urandom_range(0, 8);
						repeat (n) send_byte(pay_byte(), 1'b0, "");
						sent += n;
					end
					send_byte(btr_pkg::CH_GT, 1'b0, "");
					sent++;
				end
			endcase
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_html.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending_html.size() == 0)
			$display("** bracket_tag_to_html_rewriter: PASSED **");
		else
			$display("** bracket_tag_to_html_rewriter: FAILED **");
		$finish;
	end

endmodule
